@@ design/hc3d_pkg.sv @@
// shared types, constants and the modular reduction step for the hill decryption block
package hc3d_pkg;

  // field and datapath widths
  localparam int SYM_W  = 5;              // symbol width
  localparam int ROW_W  = 3 * SYM_W;      // one key row, three symbols
  localparam int MOD_W  = SYM_W + 1;      // modulus register width
  localparam int ACC_W  = 12;             // widest intermediate sum
  localparam int NIB_W  = 4;              // remainder bits resolved per cycle
  localparam int CHUNKS = ACC_W / NIB_W;  // remainder steps per reduction
  localparam int CHUNK_W = 2;
  localparam int KEY_N  = 9;              // entries of a 3x3 matrix
  localparam int IDX_W  = 4;
  localparam int CFG_W  = ROW_W;          // configuration data width

  localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNKS - 1);
  localparam logic [IDX_W-1:0]   KEY_LAST   = IDX_W'(KEY_N - 1);
  localparam logic [MOD_W-1:0]   MOD_LIMIT  = MOD_W'(32);
  localparam logic [MOD_W-1:0]   MOD_MIN    = MOD_W'(2);

  // reset values of the configuration registers
  localparam logic [MOD_W-1:0] MODULUS_RST = MOD_W'(26);
  localparam logic [ROW_W-1:0] KEY_A_RST   = ROW_W'(1798);
  localparam logic [ROW_W-1:0] KEY_B_RST   = ROW_W'(10765);
  localparam logic [ROW_W-1:0] KEY_C_RST   = ROW_W'(15924);

  typedef logic [SYM_W-1:0] sym_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_KEY_A   = 2'd1,
    REG_KEY_B   = 2'd2,
    REG_KEY_C   = 2'd3
  } reg_idx_e;

  // key setup sequencer
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_REDUCE,
    ST_SEARCH,
    ST_READY
  } setup_state_e;

  typedef enum logic [1:0] {
    PH_KEY,
    PH_ADJ,
    PH_DET,
    PH_SCALE
  } setup_phase_e;

  // setup status towards the item path
  typedef struct packed {
    logic ready;
    logic singular;
  } setup_status_t;

  // control of the dot product lanes
  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

  // four restoring steps of a remainder by m, most significant bit first
  function automatic sym_t mod_step4(input sym_t r, input logic [NIB_W-1:0] bits,
                                     input logic [MOD_W-1:0] m);
    logic [MOD_W-1:0] t;
    sym_t             acc;
    acc = r;
    for (int b = NIB_W - 1; b >= 0; b--) begin
      t = {acc, bits[b]};
      if (t >= m) begin
        t = t - m;
      end
      acc = t[SYM_W-1:0];
    end
    return acc;
  endfunction

endpackage

@@ design/hill_cipher_3x3_decrypt.sv @@
// 3x3 hill cipher decryption top level: key setup, three lanes and result merge
//
// A ciphertext triple is taken when start is high and busy is low; its plaintext
// appears on plain_0_o..plain_2_o with no_inverse_o, with valid_o high for exactly
// one cycle, once the lanes have loaded the dot product and run three four-bit
// remainder steps against the modulus. busy stays high while a triple is in the
// lanes; the next triple is taken only once those steps are done. The inverse
// key is derived from the configuration registers after reset and after every
// register write; busy stays high during that derivation, which runs up to 28
// reductions plus the inverse search over up to 32 candidates. The result port
// has no back-pressure: results must be taken as they appear. cfg_ready_o is
// always high.
module hill_cipher_3x3_decrypt import hc3d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  sym_t             cipher_0_i,
  input  sym_t             cipher_1_i,
  input  sym_t             cipher_2_i,
  output logic             valid_o,
  output sym_t             plain_0_o,
  output sym_t             plain_1_o,
  output sym_t             plain_2_o,
  output logic             no_inverse_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  reg_idx_e         cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic               cfg_we;
  logic [MOD_W-1:0]   m_eff;
  sym_t [KEY_N-1:0]   inv_key;
  setup_status_t      status;
  lane_ctrl_t         lane_ctrl;
  sym_t [2:0]         cipher;
  sym_t [2:0]         lane_res;
  logic               accept;
  logic               active_q, active_d;
  logic [CHUNK_W-1:0] cnt_q, cnt_d;
  logic               cap_q, cap_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  hc3d_key_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .m_eff_o     (m_eff),
    .inv_key_o   (inv_key),
    .status_o    (status)
  );

  // item handshake
  assign busy   = !status.ready || active_q;
  assign accept = start && !busy;

  // item sequencing: load, three reduction steps, capture
  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    cap_d    = 1'b0;
    if (accept) begin
      active_d = 1'b1;
      cnt_d    = '0;
    end else if (active_q) begin
      cnt_d = cnt_q + CHUNK_W'(1);
      if (cnt_q == CHUNK_LAST) begin
        active_d = 1'b0;
        cap_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      cap_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      cap_q    <= cap_d;
    end
  end

  assign lane_ctrl.load = accept;
  assign lane_ctrl.step = active_q;
  assign cipher         = {cipher_2_i, cipher_1_i, cipher_0_i};

  // one lane per plaintext symbol
  for (genvar g = 0; g < 3; g++) begin : g_lane
    hc3d_lane u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .m_i      (m_eff),
      .row_i    (inv_key[3*g +: 3]),
      .cipher_i (cipher),
      .rem_o    (lane_res[g])
    );
  end

  hc3d_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .singular_i   (status.singular),
    .lane_res_i   (lane_res),
    .valid_o      (valid_o),
    .plain_0_o    (plain_0_o),
    .plain_1_o    (plain_1_o),
    .plain_2_o    (plain_2_o),
    .no_inverse_o (no_inverse_o)
  );

  // every transfer is followed by its result strobe
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 valid_o)
    else $error("result strobe missing after item transfer");

  // no second item while one is being worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after item transfer");

  // singular key gives an all-zero plaintext
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && no_inverse_o) |->
      (plain_0_o == '0 && plain_1_o == '0 && plain_2_o == '0))
    else $error("non-zero plaintext with no inverse");

endmodule

@@ design/hc3d_key_setup.sv @@
// configuration registers and inverse key sequencer (reduce, adjugate, determinant, inverse)
module hc3d_key_setup import hc3d_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  reg_idx_e             cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic [MOD_W-1:0]     m_eff_o,
  output sym_t [KEY_N-1:0]     inv_key_o,
  output setup_status_t        status_o
);

  logic [MOD_W-1:0] modulus_q;
  logic [ROW_W-1:0] row_a_q, row_b_q, row_c_q;
  logic [MOD_W-1:0] m_eff;
  logic [3*ROW_W-1:0] key_flat;

  setup_state_e     state_q, state_d;
  setup_phase_e     phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;
  logic [ACC_W-1:0] val_q, val_d;
  sym_t             rem_q, rem_d;
  sym_t [KEY_N-1:0] k_q, k_d;
  sym_t [KEY_N-1:0] adj_q, adj_d;
  sym_t [KEY_N-1:0] e_q, e_d;
  sym_t             det_q, det_d;
  sym_t             inv_q, inv_d;
  sym_t             x_q, x_d;
  logic [MOD_W-1:0] cnt_q, cnt_d;
  logic             singular_q, singular_d;

  sym_t             red_res;
  logic [SYM_W:0]   x_sum;
  logic [ACC_W-1:0] opd;
  sym_t             p, q, r, s;
  logic             last_chunk;
  logic             found;
  logic             exhausted;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
      row_a_q   <= KEY_A_RST;
      row_b_q   <= KEY_B_RST;
      row_c_q   <= KEY_C_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MODULUS: modulus_q <= cfg_data_i[MOD_W-1:0];
        REG_KEY_A:   row_a_q   <= cfg_data_i[ROW_W-1:0];
        REG_KEY_B:   row_b_q   <= cfg_data_i[ROW_W-1:0];
        REG_KEY_C:   row_c_q   <= cfg_data_i[ROW_W-1:0];
        default:     modulus_q <= modulus_q;
      endcase
    end
  end

  // modulus saturated to the symbol range
  assign m_eff    = (modulus_q > MOD_LIMIT) ? MOD_LIMIT : modulus_q;
  assign key_flat = {row_c_q, row_b_q, row_a_q};

  // shared reduction step and search increment
  assign red_res    = mod_step4(rem_q, val_q[ACC_W-1 -: NIB_W], m_eff);
  assign last_chunk = (chunk_q == CHUNK_LAST);
  assign x_sum      = {1'b0, x_q} + {1'b0, det_q};
  assign found      = (x_q == SYM_W'(1));
  assign exhausted  = (cnt_q == m_eff - MOD_W'(1));

  // cofactor operands, entries indexed row * 3 + column
  always_comb begin
    case (idx_q)
      4'd0:    begin p = k_q[4]; q = k_q[8]; r = k_q[5]; s = k_q[7]; end
      4'd1:    begin p = k_q[2]; q = k_q[7]; r = k_q[1]; s = k_q[8]; end
      4'd2:    begin p = k_q[1]; q = k_q[5]; r = k_q[2]; s = k_q[4]; end
      4'd3:    begin p = k_q[5]; q = k_q[6]; r = k_q[3]; s = k_q[8]; end
      4'd4:    begin p = k_q[0]; q = k_q[8]; r = k_q[2]; s = k_q[6]; end
      4'd5:    begin p = k_q[2]; q = k_q[3]; r = k_q[0]; s = k_q[5]; end
      4'd6:    begin p = k_q[3]; q = k_q[7]; r = k_q[4]; s = k_q[6]; end
      4'd7:    begin p = k_q[1]; q = k_q[6]; r = k_q[0]; s = k_q[7]; end
      default: begin p = k_q[0]; q = k_q[4]; r = k_q[1]; s = k_q[3]; end
    endcase
  end

  // value to be reduced in the current phase
  always_comb begin
    case (phase_q)
      PH_KEY:   opd = ACC_W'(key_flat[SYM_W*idx_q +: SYM_W]);
      PH_ADJ:   opd = ACC_W'(p) * ACC_W'(q) + ACC_W'(m_eff) * ACC_W'(m_eff)
                      - ACC_W'(r) * ACC_W'(s);
      PH_DET:   opd = ACC_W'(k_q[0]) * ACC_W'(adj_q[0]) + ACC_W'(k_q[1]) * ACC_W'(adj_q[3])
                      + ACC_W'(k_q[2]) * ACC_W'(adj_q[6]);
      default:  opd = ACC_W'(inv_q) * ACC_W'(adj_q[idx_q]);
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    unique case (state_q)
      ST_LOAD: begin
        if (m_eff < MOD_MIN) begin
          state_d = ST_READY;
        end else begin
          state_d = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (last_chunk) begin
          if (phase_q == PH_DET) begin
            state_d = ST_SEARCH;
          end else if (idx_q != KEY_LAST) begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_LOAD;
          end else begin
            idx_d = '0;
            unique case (phase_q)
              PH_KEY: begin
                phase_d = PH_ADJ;
                state_d = ST_LOAD;
              end
              PH_ADJ: begin
                phase_d = PH_DET;
                state_d = ST_LOAD;
              end
              default: state_d = ST_READY;
            endcase
          end
        end
      end
      ST_SEARCH: begin
        if (found) begin
          phase_d = PH_SCALE;
          idx_d   = '0;
          state_d = ST_LOAD;
        end else if (exhausted) begin
          state_d = ST_READY;
        end
      end
      ST_READY: state_d = ST_READY;
      default:  state_d = ST_READY;
    endcase
    // any register write restarts the derivation
    if (cfg_we_i) begin
      state_d = ST_LOAD;
      phase_d = PH_KEY;
      idx_d   = '0;
    end
  end

  // datapath updates
  always_comb begin
    chunk_d    = chunk_q;
    val_d      = val_q;
    rem_d      = rem_q;
    k_d        = k_q;
    adj_d      = adj_q;
    e_d        = e_q;
    det_d      = det_q;
    inv_d      = inv_q;
    x_d        = x_q;
    cnt_d      = cnt_q;
    singular_d = singular_q;
    unique case (state_q)
      ST_LOAD: begin
        val_d   = opd;
        rem_d   = '0;
        chunk_d = '0;
        if (m_eff < MOD_MIN) begin
          singular_d = 1'b1;
        end
      end
      ST_REDUCE: begin
        rem_d   = red_res;
        val_d   = {val_q[ACC_W-NIB_W-1:0], NIB_W'(0)};
        chunk_d = chunk_q + CHUNK_W'(1);
        if (last_chunk) begin
          case (phase_q)
            PH_KEY: k_d[idx_q] = red_res;
            PH_ADJ: adj_d[idx_q] = red_res;
            PH_DET: begin
              det_d = red_res;
              x_d   = '0;
              cnt_d = '0;
            end
            default: begin
              e_d[idx_q] = red_res;
              if (idx_q == KEY_LAST) begin
                singular_d = 1'b0;
              end
            end
          endcase
        end
      end
      ST_SEARCH: begin
        if (found) begin
          inv_d = cnt_q[SYM_W-1:0];
        end else begin
          x_d   = (x_sum >= m_eff) ? SYM_W'(x_sum - m_eff) : x_sum[SYM_W-1:0];
          cnt_d = cnt_q + MOD_W'(1);
          if (exhausted) begin
            singular_d = 1'b1;
          end
        end
      end
      default: chunk_d = chunk_q;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      phase_q    <= PH_KEY;
      idx_q      <= '0;
      chunk_q    <= '0;
      singular_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      chunk_q    <= chunk_d;
      singular_q <= singular_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    rem_q <= rem_d;
    k_q   <= k_d;
    adj_q <= adj_d;
    e_q   <= e_d;
    det_q <= det_d;
    inv_q <= inv_d;
    x_q   <= x_d;
    cnt_q <= cnt_d;
  end

  assign m_eff_o           = m_eff;
  assign inv_key_o         = e_q;
  assign status_o.ready    = (state_q == ST_READY);
  assign status_o.singular = singular_q;

  // a register write always drops ready in the following cycle
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (state_q != ST_READY))
    else $error("key setup still ready after a register write");

  // a found inverse moves on to scaling the adjugate
  a_found_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH && found && !cfg_we_i) |=> (phase_q == PH_SCALE))
    else $error("inverse found but scaling phase not entered");

endmodule

@@ design/hc3d_lane.sv @@
// one dot product lane: inverse key row times ciphertext, reduced modulo m
module hc3d_lane import hc3d_pkg::*; (
  input  logic             clk_i,
  input  lane_ctrl_t       ctrl_i,
  input  logic [MOD_W-1:0] m_i,
  input  sym_t [2:0]       row_i,
  input  sym_t [2:0]       cipher_i,
  output sym_t             rem_o
);

  logic [ACC_W-1:0] acc_q, acc_d;
  sym_t             rem_q, rem_d;
  logic [ACC_W-1:0] dot;

  // three narrow products summed
  assign dot = ACC_W'(row_i[0]) * ACC_W'(cipher_i[0])
             + ACC_W'(row_i[1]) * ACC_W'(cipher_i[1])
             + ACC_W'(row_i[2]) * ACC_W'(cipher_i[2]);

  // load the sum, then peel four bits into the remainder each step
  always_comb begin
    acc_d = acc_q;
    rem_d = rem_q;
    if (ctrl_i.load) begin
      acc_d = dot;
      rem_d = '0;
    end else if (ctrl_i.step) begin
      acc_d = {acc_q[ACC_W-NIB_W-1:0], NIB_W'(0)};
      rem_d = mod_step4(rem_q, acc_q[ACC_W-1 -: NIB_W], m_i);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign rem_o = rem_q;

endmodule

@@ design/hc3d_merge.sv @@
// merge stage: collects the lane remainders into one result strobe
module hc3d_merge import hc3d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cap_i,
  input  logic       singular_i,
  input  sym_t [2:0] lane_res_i,
  output logic       valid_o,
  output sym_t       plain_0_o,
  output sym_t       plain_1_o,
  output sym_t       plain_2_o,
  output logic       no_inverse_o
);

  logic       valid_q;
  sym_t [2:0] plain_q;
  logic       noinv_q;

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cap_i;
    end
  end

  // result payload, zeroed for a singular key
  always_ff @(posedge clk_i) begin
    if (cap_i) begin
      plain_q <= singular_i ? '0 : lane_res_i;
      noinv_q <= singular_i;
    end
  end

  assign valid_o      = valid_q;
  assign plain_0_o    = plain_q[0];
  assign plain_1_o    = plain_q[1];
  assign plain_2_o    = plain_q[2];
  assign no_inverse_o = noinv_q;

endmodule
